// ===== sv/mp_pkg.sv =====
// Package for the modular power unit: field widths, reset constant and the
// control/status structs between the sequencer and the shared multiply-reduce unit.
// No dependencies.
`timescale 1ns / 1ps

package mp_pkg;

  localparam int BASE_BITS  = 32;
  localparam int EXP_FIELD  = 63;
  localparam int EXP_LSB    = BASE_BITS;
  localparam int POWER_BITS = 32;
  localparam int IN_BITS    = 96;
  localparam int OUT_BITS   = 32;
  localparam int CFG_BITS   = 32;

  localparam logic [CFG_BITS-1:0] MODULUS_RESET = 32'd1000000007;

  // Request to the shared unit: start one operation, either a plain reduction
  // of the base or a modular multiply of two reduced operands.
  typedef struct packed {
    logic start;
    logic reduce_only;
  } mm_ctrl_t;

  typedef struct packed {
    logic done;
  } mm_stat_t;

endpackage

// ===== sv/mp_modmul.sv =====
// Shared multiply-reduce unit of the modular power unit: a combinational multiply, then
// a restoring reduction that retires one dividend bit per cycle.
// Depends on mp_pkg.
`timescale 1ns / 1ps

module mp_modmul #(
  parameter int MOD_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  mp_pkg::mm_ctrl_t               ctrl,
  input  logic [MOD_BITS-1:0]            op_a,
  input  logic [MOD_BITS-1:0]            op_b,
  input  logic [mp_pkg::BASE_BITS-1:0]   base,
  input  logic [MOD_BITS-1:0]            modulus,
  output mp_pkg::mm_stat_t               stat,
  output logic [MOD_BITS-1:0]            result
);

  localparam int SW = mp_pkg::BASE_BITS;
  localparam int CW = $clog2(SW + 1);

  typedef enum logic [1:0] {
    U_IDLE = 2'b01,
    U_RED  = 2'b10
  } ustate_t;

  ustate_t                 state;
  logic [CW-1:0]           cnt;
  logic [MOD_BITS-1:0]     rem;
  logic [SW-1:0]           shift;
  logic                    done;

  logic [2*MOD_BITS-1:0]   prod;
  logic [SW-1:0]           prod_lo;
  logic [MOD_BITS:0]       m_ext;
  logic [MOD_BITS:0]       rs;
  logic [MOD_BITS:0]       diff;

  assign prod    = (2*MOD_BITS)'(op_a) * (2*MOD_BITS)'(op_b);
  assign prod_lo = SW'(prod[MOD_BITS-1:0]) << (SW - MOD_BITS);

  // A zero modulus acts as 2^MOD_BITS, so the reduction simply drops the carry.
  assign m_ext = {(modulus == '0), modulus};
  assign rs    = {rem, shift[SW-1]};
  assign diff  = rs - m_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        U_IDLE: begin
          if (ctrl.start) begin
            state <= U_RED;
            if (ctrl.reduce_only) begin
              rem   <= '0;
              shift <= base;
              cnt   <= CW'(SW);
            end else begin
              // Operands are reduced, so the high half is already below the modulus.
              rem   <= prod[2*MOD_BITS-1:MOD_BITS];
              shift <= prod_lo;
              cnt   <= CW'(MOD_BITS);
            end
          end
        end
        U_RED: begin
          if (rs >= m_ext) begin
            rem <= diff[MOD_BITS-1:0];
          end else begin
            rem <= rs[MOD_BITS-1:0];
          end
          shift <= shift << 1;
          cnt   <= cnt - 1'b1;
          if (cnt == CW'(1)) begin
            state <= U_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= U_IDLE;
      endcase
    end
  end

  assign stat.done = done;
  assign result    = rem;

endmodule

// ===== sv/modular_power_unit.sv =====
// Top level of the modular power unit: stream ports, modulus register and the
// square-and-multiply sequencer around one shared multiply-reduce unit.
// Depends on mp_pkg and mp_modmul.
`timescale 1ns / 1ps

// Each item carries a base and an exponent and yields one item holding
// base^exponent mod modulus (1 when the exponent is zero). Items are handled one
// at a time; s_tready is high only while the sequencer is idle, and a finished
// result may wait in the output register while the next item is taken. All the
// arithmetic runs on one multiply-reduce unit, which first reduces the base and
// then squares for each exponent bit from the top set bit down and multiplies
// for each set bit; leading zero exponent bits are skipped without a multiply,
// and a zero exponent needs no multiply-reduce work at all.

module modular_power_unit #(
  parameter int EXP_BITS = 63,
  parameter int MOD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [mp_pkg::IN_BITS-1:0]    s_tdata,   // [31:0] base, [94:32] exponent
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [mp_pkg::OUT_BITS-1:0]   m_tdata,   // [31:0] power
  input  logic                          cfg_we,
  input  logic [mp_pkg::CFG_BITS-1:0]   cfg_wdata
);

  localparam int EW = $clog2(EXP_BITS + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_BASE = 6'b000010,
    S_BIT  = 6'b000100,
    S_SQ   = 6'b001000,
    S_MUL  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t                state;
  logic [MOD_BITS-1:0]   modulus;
  logic [EXP_BITS-1:0]   exp_reg;
  logic [EW-1:0]         cnt;
  logic                  lead;
  logic [MOD_BITS-1:0]   r;
  logic [MOD_BITS-1:0]   b_red;
  logic [mp_pkg::POWER_BITS-1:0] power;

  logic [EXP_BITS-1:0]   exp_in;
  logic                  exp_msb;
  logic                  skip_bit;
  logic                  out_free;
  logic [MOD_BITS-1:0]   r_init;

  mp_pkg::mm_ctrl_t      ctrl;
  mp_pkg::mm_stat_t      stat;
  logic [MOD_BITS-1:0]   op_a;
  logic [MOD_BITS-1:0]   op_b;
  logic [MOD_BITS-1:0]   res;

  assign exp_in   = s_tdata[mp_pkg::EXP_LSB +: EXP_BITS];
  assign exp_msb  = exp_reg[EXP_BITS-1];
  assign skip_bit = lead && !exp_msb;
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE);
  // One reduced modulo the modulus: zero only for a modulus of one.
  assign r_init   = (modulus == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);

  mp_modmul #(
    .MOD_BITS(MOD_BITS)
  ) u_modmul (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .op_a    (op_a),
    .op_b    (op_b),
    .base    (s_tdata[mp_pkg::BASE_BITS-1:0]),
    .modulus (modulus),
    .stat    (stat),
    .result  (res)
  );

  always_comb begin
    ctrl = '0;
    op_a = r;
    op_b = r;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid && (exp_in != '0)) begin
          ctrl.start       = 1'b1;
          ctrl.reduce_only = 1'b1;
        end
      end
      S_BIT: begin
        if ((cnt != '0) && !skip_bit) begin
          ctrl.start = 1'b1;
        end
      end
      S_SQ: begin
        if (stat.done && exp_msb) begin
          ctrl.start = 1'b1;
          op_a       = res;
          op_b       = b_red;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= mp_pkg::MODULUS_RESET[MOD_BITS-1:0];
    end else if (cfg_we) begin
      modulus <= cfg_wdata[MOD_BITS-1:0];
    end
  end

  // The output register loads in the done state and empties when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      lead     <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            exp_reg <= exp_in;
            cnt     <= EW'(EXP_BITS);
            lead    <= 1'b1;
            if (exp_in == '0) begin
              // A zero exponent returns 1 without reduction.
              r     <= MOD_BITS'(1);
              state <= S_DONE;
            end else begin
              r     <= r_init;
              state <= S_BASE;
            end
          end
        end
        S_BASE: begin
          if (stat.done) begin
            b_red <= res;
            state <= S_BIT;
          end
        end
        S_BIT: begin
          if (cnt == '0) begin
            state <= S_DONE;
          end else if (skip_bit) begin
            // Squaring the reduced one changes nothing until the first set bit.
            exp_reg <= exp_reg << 1;
            cnt     <= cnt - 1'b1;
          end else begin
            lead  <= 1'b0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          if (stat.done) begin
            r <= res;
            if (exp_msb) begin
              state <= S_MUL;
            end else begin
              exp_reg <= exp_reg << 1;
              cnt     <= cnt - 1'b1;
              state   <= S_BIT;
            end
          end
        end
        S_MUL: begin
          if (stat.done) begin
            r       <= res;
            exp_reg <= exp_reg << 1;
            cnt     <= cnt - 1'b1;
            state   <= S_BIT;
          end
        end
        S_DONE: begin
          if (out_free) begin
            power    <= mp_pkg::POWER_BITS'(r);
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = mp_pkg::OUT_BITS'(power);

endmodule

// ===== sv/mp_checker.sv =====
// Port-level checker for the modular power unit, bound to the top level.
// Depends on mp_pkg and on the port list of modular_power_unit.
`timescale 1ns / 1ps

module mp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [mp_pkg::IN_BITS-1:0]    s_tdata,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [mp_pkg::OUT_BITS-1:0]   m_tdata
);

  // A stalled result item keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result item changed while stalled");

  a_reset_state: assert property (@(posedge clk)
    rst |=> (!m_tvalid && s_tready))
    else $error("block not idle after reset");

  // Items are taken one at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while an item is in progress");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result item appeared without work in progress");

  // A zero exponent is answered with 1, through the done state and the output register, when the output is free.
  a_zero_exp: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !m_tvalid && (s_tdata[94:32] == '0))
      |=> ##1 (m_tvalid && (m_tdata == mp_pkg::OUT_BITS'(1))))
    else $error("zero exponent did not give 1");

endmodule

bind modular_power_unit mp_checker u_mp_checker (.*);

// ===== tb/mp_power_checker.sv =====
// Checker for the modular power unit: watches the input, result and modulus
// channels, predicts every power and compares it with what the block returns.
// Depends on mp_pkg.
`timescale 1ns / 1ps

module mp_power_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  input  logic [mp_pkg::IN_BITS-1:0]  s_tdata,
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic [mp_pkg::OUT_BITS-1:0] m_tdata,
  input  logic                        cfg_we,
  input  logic [mp_pkg::CFG_BITS-1:0] cfg_wdata,
  output int                          mismatch_total,
  output int                          outstanding
);

  logic [mp_pkg::CFG_BITS-1:0]   modulus_copy = mp_pkg::MODULUS_RESET;
  logic [mp_pkg::POWER_BITS-1:0] expected_powers[$];

  // A zero modulus behaves as 2^32, so reduction is a plain truncation.
  function automatic logic [63:0] fold_mod(input logic [63:0] v,
                                           input logic [31:0] modulus);
    if (modulus == 32'd0) return v & 64'h0000_0000_FFFF_FFFF;
    return v % {32'd0, modulus};
  endfunction

  function automatic logic [31:0] predict_power(input logic [31:0] base,
                                                input logic [62:0] exponent,
                                                input logic [31:0] modulus);
    logic [63:0] b;
    logic [63:0] r;
    int          i;
    if (exponent == 63'd0) return 32'd1;
    b = fold_mod({32'd0, base}, modulus);
    r = fold_mod(64'd1, modulus);
    for (i = 62; i >= 0; i--) begin
      r = fold_mod(r * r, modulus);
      if (exponent[i]) r = fold_mod(r * b, modulus);
    end
    return r[31:0];
  endfunction

  always @(posedge clk) begin : monitor
    logic [31:0] want;
    if (rst) begin
      modulus_copy <= mp_pkg::MODULUS_RESET;
      expected_powers.delete();
    end else begin
      if (cfg_we) modulus_copy <= cfg_wdata;
      if (s_tvalid && s_tready) begin
        expected_powers.push_back(predict_power(
          s_tdata[mp_pkg::BASE_BITS-1:0],
          s_tdata[mp_pkg::EXP_LSB +: mp_pkg::EXP_FIELD],
          modulus_copy));
      end
      if (m_tvalid && m_tready) begin
        if (expected_powers.size() == 0) begin
          $display("%0t: unexpected power item: expected none, actual %h",
                   $time, m_tdata);
          mismatch_total <= mismatch_total + 1;
        end else begin
          want = expected_powers.pop_front();
          if (m_tdata !== want) begin
            $display("%0t: power mismatch: expected %h, actual %h",
                     $time, want, m_tdata);
            mismatch_total <= mismatch_total + 1;
          end
        end
      end
    end
    outstanding <= expected_powers.size();
  end

endmodule

// ===== tb/tb_modular_power_unit.sv =====
// Testbench top for the modular power unit: clock, reset, stimulus on the input
// and modulus ports, random back-pressure, and the final verdict.
// Depends on mp_pkg, modular_power_unit and mp_power_checker.
`timescale 1ns / 1ps

module tb_modular_power_unit;

  localparam int        HOLD_CYCLES  = 3000;
  localparam int        PHASE_ITEMS  = 250;
  localparam logic [62:0] EXP_MAX    = {63{1'b1}};

  logic                        clk       = 1'b0;
  logic                        rst       = 1'b1;
  logic                        s_tvalid  = 1'b0;
  logic                        s_tready;
  logic [mp_pkg::IN_BITS-1:0]  s_tdata   = '0;
  logic                        m_tvalid;
  logic                        m_tready  = 1'b0;
  logic [mp_pkg::OUT_BITS-1:0] m_tdata;
  logic                        cfg_we    = 1'b0;
  logic [mp_pkg::CFG_BITS-1:0] cfg_wdata = '0;

  int          mismatches;
  int          pending;
  logic        quiet        = 1'b0;
  int          hold_trigger = 0;
  int          hold_seen    = 0;
  int          hold_left    = 0;
  logic [31:0] cur_modulus  = mp_pkg::MODULUS_RESET;

  always #10 clk = ~clk;

  modular_power_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),   // [31:0] base, [94:32] exponent, [95] zero
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),   // [31:0] power
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  mp_power_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .mismatch_total (mismatches),
    .outstanding    (pending)
  );

  // Result side: random stalls, plus one long hold-off counted here.
  always @(posedge clk) begin
    if (hold_seen != hold_trigger) begin
      hold_seen <= hold_trigger;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (quiet) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= 16);
    end
  end

  task automatic send_item(input logic [31:0] base, input logic [62:0] exponent);
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, exponent, base};
    do @(posedge clk); while (!s_tready);
  endtask

  // Lowers valid and waits until every predicted power has come back.
  task automatic drain_powers();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_modulus(input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we      <= 1'b0;
    cur_modulus = value;
  endtask

  function automatic logic [31:0] rand_base();
    case ($urandom_range(9))
      0:       return $urandom_range(3);
      1:       return 32'hFFFF_FFFF;
      2:       return cur_modulus + $urandom_range(2) - 1;
      default: return $urandom;
    endcase
  endfunction

  // Most exponents are short, since latency grows with the exponent's width.
  function automatic logic [62:0] rand_exponent();
    logic [63:0] raw;
    int          pick;
    int          w;
    raw  = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 3) w = 63;
    else if (pick < 15) w = $urandom_range(9, 20);
    else w = $urandom_range(8);
    if (w < 63) raw = raw & ((64'd1 << w) - 64'd1);
    return raw[62:0];
  endfunction

  task automatic random_phase(input logic [31:0] modulus, input int index);
    int n;
    set_modulus(modulus);
    for (n = 0; n < PHASE_ITEMS; n++) begin
      if (index == 2 && n == 0) quiet <= 1'b1;
      if (index == 2 && n == 150) quiet <= 1'b0;
      if (index == 1 && n == 40) hold_trigger <= hold_trigger + 1;
      send_item(rand_base(), rand_exponent());
      if (!quiet && $urandom_range(99) < 16) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
    drain_powers();
  endtask

  initial begin
    logic [31:0] small_mod;
    logic [31:0] wide_mod;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed items under the modulus left by reset.
    send_item(32'd0, 63'd0);
    send_item(32'hFFFF_FFFF, 63'd0);
    send_item(32'd0, 63'd5);
    send_item(32'd1, EXP_MAX);
    send_item(32'hFFFF_FFFF, 63'd1);
    send_item(32'hFFFF_FFFF, EXP_MAX);
    send_item(32'd2, 63'd1 << 62);
    send_item(mp_pkg::MODULUS_RESET, 63'd3);
    send_item(mp_pkg::MODULUS_RESET + 32'd1, 63'h5555_5555_5555_5555);
    send_item(32'd12345, 63'h2AAA_AAAA_AAAA_AAAA);
    send_item(32'd3, {31'd0, mp_pkg::MODULUS_RESET - 32'd2});
    drain_powers();

    // A modulus of one still gives 1 for a zero exponent.
    set_modulus(32'd1);
    send_item(32'd5, 63'd0);
    send_item(32'd7, 63'd9);
    drain_powers();

    // A zero modulus wraps the arithmetic at 2^32.
    set_modulus(32'd0);
    send_item(32'd3, 63'd40);
    send_item(32'hFFFF_FFFF, EXP_MAX);
    send_item(32'd0, 63'd0);
    drain_powers();

    set_modulus(32'hFFFF_FFFF);
    send_item(32'hFFFF_FFFF, 63'd7);
    send_item(32'hFFFF_FFFE, EXP_MAX);
    drain_powers();

    set_modulus(32'd2);
    send_item(32'd3, EXP_MAX);
    send_item(32'd4, 63'd1);
    drain_powers();

    small_mod = $urandom_range(3, 255);
    wide_mod  = $urandom;
    if (wide_mod == 32'd0) wide_mod = 32'd1;
    random_phase(small_mod, 0);
    random_phase(wide_mod, 1);
    random_phase(32'hFFFF_FFFF, 2);
    random_phase(32'd1, 3);
    random_phase(32'd2, 4);
    random_phase(mp_pkg::MODULUS_RESET, 5);

    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("tb_modular_power_unit: PASS");
    end else begin
      $display("tb_modular_power_unit: FAIL");
    end
    $finish;
  end

  initial begin
    #600000000;
    $display("tb_modular_power_unit: FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/mp_pkg.sv
sv/mp_modmul.sv
sv/modular_power_unit.sv
sv/mp_checker.sv
tb/mp_power_checker.sv
tb/tb_modular_power_unit.sv
